// File: rtl/value_noise_3d_cosine_interp_assert.svh
// Assertion macros for the value noise block.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef VALUE_NOISE_3D_COSINE_INTERP_ASSERT_SVH
`define VALUE_NOISE_3D_COSINE_INTERP_ASSERT_SVH

// The consequent must hold at the same edge as the antecedent.
`define VN3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold at the next clock edge after the antecedent.
`define VN3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/vn3_pkg.sv
// Shared types and constants of the value noise block.
// No dependencies.
package vn3_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_t;

  localparam int VAL_W   = 10;
  localparam int IDX_W   = 12;
  localparam int COORD_W = 32;
  localparam int NOISE_W = 16;
  localparam int WGT_W   = 17;

  // 15000 in Q16.16.
  localparam logic [COORD_W-1:0] OFFSET_Q16 = 32'd983040000;

  typedef logic [VAL_W-1:0] lat_val_t;
  typedef logic [WGT_W-1:0] weight_t;

endpackage

// File: rtl/vn3_if.sv
// Valid/ready channel interfaces for the value noise block.
// Depends on vn3_pkg.
interface vn3_in_if;
  logic                          valid;
  logic                          ready;
  vn3_pkg::op_t                  operation;
  logic [vn3_pkg::IDX_W-1:0]     entry_index;
  logic [vn3_pkg::VAL_W-1:0]     entry_value;
  logic signed [vn3_pkg::COORD_W-1:0] coord_x;
  logic signed [vn3_pkg::COORD_W-1:0] coord_y;
  logic signed [vn3_pkg::COORD_W-1:0] coord_z;
  modport source (output valid, operation, entry_index, entry_value,
                  coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, operation, entry_index, entry_value,
                coord_x, coord_y, coord_z, output ready);
endinterface

interface vn3_out_if;
  logic                        valid;
  logic                        ready;
  logic [vn3_pkg::NOISE_W-1:0] noise_value;
  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface

// File: rtl/value_noise_3d_cosine_interp.sv
// Nine-stage pipeline: one item is taken every cycle unless every stage is
// full and the output is stalled. Each stage advances on its own, so a
// stalled output only holds back stages that are full. Table writes take
// effect in stage four, where the eight replicated lattice RAMs are read.
// Reset clears the stage valid bits; the table is undefined until written.
module value_noise_3d_cosine_interp #(
  parameter int SIZE_X          = 16,
  parameter int SIZE_Y          = 16,
  parameter int SIZE_Z          = 16,
  parameter int WEIGHT_ROM_BITS = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  vn3_in_if.sink    in_ch,
  vn3_out_if.source out_ch
);
  import vn3_pkg::*;

  `include "value_noise_3d_cosine_interp_assert.svh"

  localparam int DEPTH     = SIZE_X * SIZE_Y * SIZE_Z;
  localparam int AW        = $clog2(DEPTH);
  localparam int MAX_SIZE  = (SIZE_X > SIZE_Y) ? ((SIZE_X > SIZE_Z) ? SIZE_X : SIZE_Z)
                                               : ((SIZE_Y > SIZE_Z) ? SIZE_Y : SIZE_Z);
  localparam int CW        = $clog2(MAX_SIZE);
  localparam int ROM_DEPTH = 2 ** WEIGHT_ROM_BITS;
  localparam int SIZES [3] = '{SIZE_X, SIZE_Y, SIZE_Z};
  localparam logic [32:0] MOD_M [3] = '{
    33'(((64'd1 << 32) + 64'(SIZE_X) - 64'd1) / 64'(SIZE_X)),
    33'(((64'd1 << 32) + 64'(SIZE_Y) - 64'd1) / 64'(SIZE_Y)),
    33'(((64'd1 << 32) + 64'(SIZE_Z) - 64'd1) / 64'(SIZE_Z))};
  localparam int DIV_SHIFT = 37;
  localparam logic [27:0] DIV_M = 28'(((64'd1 << DIV_SHIFT) + 64'd999) / 64'd1000);
  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam longint unsigned PI_Q30  = 64'd3373259426;

  typedef logic [WGT_W-1:0] wrom_t [ROM_DEPTH];

  // Weight (1 - cos(pi*t))/2 in Q16, built as a sine series at elaboration.
  function automatic wrom_t build_wrom();
    wrom_t rom;
    longint unsigned t, s, x, x2, h, sn, sum, w;
    logic neg;
    for (int a = 0; a < ROM_DEPTH; a++) begin
      t   = 64'(a) << (16 - WEIGHT_ROM_BITS);
      neg = t < 64'd32768;
      s   = neg ? (64'd32768 - t) : (t - 64'd32768);
      x   = (PI_Q30 * s) >> 16;
      x2  = (x * x) >> 30;
      h   = ONE_Q30 - x2 / 64'd110;
      h   = ONE_Q30 - ((x2 * h) >> 30) / 64'd72;
      h   = ONE_Q30 - ((x2 * h) >> 30) / 64'd42;
      h   = ONE_Q30 - ((x2 * h) >> 30) / 64'd20;
      h   = ONE_Q30 - ((x2 * h) >> 30) / 64'd6;
      sn  = (x * h) >> 30;
      if (neg) begin
        sum = (sn >= ONE_Q30) ? 64'd0 : ONE_Q30 - sn;
      end else begin
        sum = ONE_Q30 + sn;
      end
      w = (sum + 64'd16384) >> 15;
      if (w > 64'd65536) begin
        w = 64'd65536;
      end
      rom[a] = WGT_W'(w);
    end
    return rom;
  endfunction

  localparam wrom_t WROM = build_wrom();

  function automatic logic [25:0] blend_q16(logic [25:0] a, logic [25:0] b, weight_t w);
    logic [43:0] acc;
    acc = 44'(a) * 44'(17'd65536 - w) + 44'(b) * 44'(w) + 44'd32768;
    return acc[41:16];
  endfunction

  function automatic logic [AW-1:0] flat_addr(logic [CW-1:0] x, logic [CW-1:0] y,
                                              logic [CW-1:0] z);
    return AW'((int'(x) * SIZE_Y + int'(y)) * SIZE_Z + int'(z));
  endfunction

  // Stage valid bits and per-stage load enables.
  logic [9:1] vld_r;
  logic [9:1] ld;

  always_comb begin
    ld[9] = !vld_r[9] || out_ch.ready;
    for (int k = 8; k >= 1; k--) begin
      ld[k] = !vld_r[k] || ld[k+1];
    end
  end

  assign in_ch.ready = ld[1];

  op_t              op_r   [1:4];
  logic [IDX_W-1:0] idx_r  [1:4];
  lat_val_t         wval_r [1:4];

  logic [COORD_W-1:0] pos1_r  [3];
  logic [15:0]        quo2_r  [3];
  logic [15:0]        int2_r  [3];
  weight_t            wgt2_r  [3];
  logic [CW-1:0]      cell3_r [3];
  logic [CW-1:0]      next3_r [3];
  weight_t            wgt3_r  [3];
  logic [AW-1:0]      addr4_r [8];
  weight_t            wgt4_r  [3];
  weight_t            wgt5_r  [3];
  lat_val_t           corner5 [8];
  logic [25:0]        edge6_r [4];
  weight_t            wy6_r, wz6_r, wz7_r;
  logic [25:0]        face7_r [2];
  logic [25:0]        v8_r;
  logic [NOISE_W-1:0] noise9_r;

  logic [COORD_W-1:0] coord_in [3];
  logic               ram_we, ram_re;

  assign coord_in[0] = in_ch.coord_x;
  assign coord_in[1] = in_ch.coord_y;
  assign coord_in[2] = in_ch.coord_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 1; k <= 9; k++) begin
        if (ld[k]) begin
          if (k == 1) begin
            vld_r[k] <= in_ch.valid;
          end else if (k == 5) begin
            // Writes end in stage four; only evaluations go on.
            vld_r[k] <= vld_r[4] && (op_r[4] == OP_EVAL);
          end else begin
            vld_r[k] <= vld_r[k-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [32:0] shifted;
    logic [48:0]        prod;
    logic [15:0]        rem;
    logic [26:0]        sum_e;
    logic [26:0]        rounded;
    logic [54:0]        dprod;
    logic [17:0]        quot;
    // Stage 1: offset and clamp.
    if (ld[1]) begin
      op_r[1]   <= in_ch.operation;
      idx_r[1]  <= in_ch.entry_index;
      wval_r[1] <= in_ch.entry_value;
      for (int c = 0; c < 3; c++) begin
        shifted   = {coord_in[c][COORD_W-1], coord_in[c]} + {1'b0, OFFSET_Q16};
        pos1_r[c] <= shifted[32] ? '0 : shifted[31:0];
      end
    end
    // Stage 2: reciprocal quotient of the integer part, weight ROM read.
    if (ld[2]) begin
      op_r[2]   <= op_r[1];
      idx_r[2]  <= idx_r[1];
      wval_r[2] <= wval_r[1];
      for (int c = 0; c < 3; c++) begin
        prod      = 49'(pos1_r[c][31:16]) * 49'(MOD_M[c]);
        quo2_r[c] <= prod[47:32];
        int2_r[c] <= pos1_r[c][31:16];
        wgt2_r[c] <= WROM[pos1_r[c][15 -: WEIGHT_ROM_BITS]];
      end
    end
    // Stage 3: remainder and wrapped neighbor.
    if (ld[3]) begin
      op_r[3]   <= op_r[2];
      idx_r[3]  <= idx_r[2];
      wval_r[3] <= wval_r[2];
      for (int c = 0; c < 3; c++) begin
        rem = int2_r[c] - 16'(quo2_r[c] * 16'(SIZES[c]));
        if (rem >= 16'(SIZES[c])) begin
          rem = rem - 16'(SIZES[c]);
        end
        cell3_r[c] <= CW'(rem);
        next3_r[c] <= (rem == 16'(SIZES[c] - 1)) ? '0 : CW'(rem + 16'd1);
        wgt3_r[c]  <= wgt2_r[c];
      end
    end
    // Stage 4: corner addresses; bit 0 picks x, bit 1 y, bit 2 z.
    if (ld[4]) begin
      op_r[4]   <= op_r[3];
      idx_r[4]  <= idx_r[3];
      wval_r[4] <= wval_r[3];
      wgt4_r    <= wgt3_r;
      for (int k = 0; k < 8; k++) begin
        addr4_r[k] <= flat_addr(k[0] ? next3_r[0] : cell3_r[0],
                                k[1] ? next3_r[1] : cell3_r[1],
                                k[2] ? next3_r[2] : cell3_r[2]);
      end
    end
    // Stage 5 gets the corner values from the RAM output registers.
    if (ld[5]) begin
      wgt5_r <= wgt4_r;
    end
    // Stage 6: blends along x; corner values are integers, so no rounding.
    if (ld[6]) begin
      for (int m = 0; m < 4; m++) begin
        sum_e = 27'(corner5[2*m]) * 27'(17'd65536 - wgt5_r[0])
              + 27'(corner5[2*m+1]) * 27'(wgt5_r[0]);
        edge6_r[m] <= sum_e[25:0];
      end
      wy6_r <= wgt5_r[1];
      wz6_r <= wgt5_r[2];
    end
    // Stage 7: blends along y.
    if (ld[7]) begin
      face7_r[0] <= blend_q16(edge6_r[0], edge6_r[1], wy6_r);
      face7_r[1] <= blend_q16(edge6_r[2], edge6_r[3], wy6_r);
      wz7_r      <= wz6_r;
    end
    // Stage 8: blend along z.
    if (ld[8]) begin
      v8_r <= blend_q16(face7_r[0], face7_r[1], wz7_r);
    end
    // Stage 9: rounded divide by 1000 through a reciprocal, then saturate.
    if (ld[9]) begin
      rounded  = 27'(v8_r) + 27'd500;
      dprod    = 55'(rounded) * 55'(DIV_M);
      quot     = dprod[54:DIV_SHIFT];
      noise9_r <= (quot > 18'd65535) ? '1 : quot[15:0];
    end
  end

  assign ram_re = ld[5] && vld_r[4];
  assign ram_we = ld[5] && vld_r[4] && (op_r[4] == OP_WRITE) && (int'(idx_r[4]) < DEPTH);

  // Eight copies of the table so that all corners are read in the same cycle.
  for (genvar k = 0; k < 8; k++) begin : g_ram
    vn3_lattice_ram #(.AW(AW)) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (AW'(idx_r[4])),
      .wdata (wval_r[4]),
      .re    (ram_re),
      .raddr (addr4_r[k]),
      .rdata (corner5[k])
    );
  end

  assign out_ch.valid       = vld_r[9];
  assign out_ch.noise_value = noise9_r;

  `VN3_ASSERT_NEXT(a_write_ends, vld_r[4] && op_r[4] == OP_WRITE && ld[5], !vld_r[5], "write reached blend stage")
  `VN3_ASSERT_NOW(a_full_when_blocked, !in_ch.ready, (&vld_r) && !out_ch.ready, "input blocked with a free stage")
  `VN3_ASSERT_NOW(a_weight_range, vld_r[3], wgt3_r[0] <= 17'd65536 && wgt3_r[1] <= 17'd65536 && wgt3_r[2] <= 17'd65536, "weight above one")
endmodule

// File: rtl/vn3_lattice_ram.sv
// One copy of the lattice table: one write port, one registered read port.
// Depends on vn3_pkg.
module vn3_lattice_ram #(
  parameter int AW = 12
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  vn3_pkg::lat_val_t   wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output vn3_pkg::lat_val_t   rdata
);
  import vn3_pkg::*;

  lat_val_t mem [2**AW];
  lat_val_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the 3-D value noise block with cosine weights.
// Depends on vn3_pkg, the vn3_in_if and vn3_out_if interfaces and the block itself.
module tb_top;
  import vn3_pkg::*;

  localparam int SX = 16;
  localparam int SY = 16;
  localparam int SZ = 16;
  localparam int ROM_BITS = 10;
  localparam int DEPTH = SX * SY * SZ;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam longint unsigned PI_Q30  = 64'd3373259426;

  logic clk;
  logic rst_n;

  vn3_in_if  in_ch ();
  vn3_out_if out_ch ();

  value_noise_3d_cosine_interp #(
    .SIZE_X(SX), .SIZE_Y(SY), .SIZE_Z(SZ), .WEIGHT_ROM_BITS(ROM_BITS)
  ) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Local copy of the lattice and a record of which entries hold data.
  lat_val_t lattice [DEPTH];
  bit       loaded  [DEPTH];
  logic [NOISE_W-1:0] noise_expected [$];
  int  error_count;
  bit  calm;
  int  hold_cycles;

  task automatic report_mismatch(string what, longint exp_v, longint got_v);
    $display("mismatch: %s expected %0d got %0d at %0t", what, exp_v, got_v, $time);
    error_count++;
  endtask

  function automatic longint unsigned cos_weight(logic [15:0] frac);
    int shift;
    longint unsigned t, s, x, x2, h, sn, sum, w;
    bit neg;
    shift = 16 - ROM_BITS;
    t = (longint'(frac) >> shift) << shift;
    neg = t < 32768;
    s = neg ? 32768 - t : t - 32768;
    x = (PI_Q30 * s) >> 16;
    x2 = (x * x) >> 30;
    h = ONE_Q30 - x2 / 110;
    h = ONE_Q30 - ((x2 * h) >> 30) / 72;
    h = ONE_Q30 - ((x2 * h) >> 30) / 42;
    h = ONE_Q30 - ((x2 * h) >> 30) / 20;
    h = ONE_Q30 - ((x2 * h) >> 30) / 6;
    sn = (x * h) >> 30;
    if (neg) sum = (sn >= ONE_Q30) ? 0 : ONE_Q30 - sn;
    else sum = ONE_Q30 + sn;
    w = (sum + 16384) >> 15;
    if (w > 65536) w = 65536;
    return w;
  endfunction

  function automatic longint unsigned lerp_q16(longint unsigned a, longint unsigned b,
                                               longint unsigned w);
    return (a * (65536 - w) + b * w + 32768) >> 16;
  endfunction

  function automatic longint unsigned shifted_coord(logic signed [31:0] c);
    longint v;
    v = longint'(c) + longint'(OFFSET_Q16);
    if (v < 0) v = 0;
    return longint'(v);
  endfunction

  function automatic int flat_index(int x, int y, int z);
    return (x * SY + y) * SZ + z;
  endfunction

  // Lattice cell and neighbor along one axis.
  function automatic void cell_of(logic signed [31:0] c, int size, output int lo, output int hi);
    lo = int'((shifted_coord(c) >> 16) % size);
    hi = (lo + 1 >= size) ? 0 : lo + 1;
  endfunction

  function automatic logic [NOISE_W-1:0] noise_at(logic signed [31:0] cx,
      logic signed [31:0] cy, logic signed [31:0] cz);
    int ix, jx, iy, jy, iz, jz;
    longint unsigned wx, wy, wz, e00, e10, e01, e11, f0, f1, v, r;
    cell_of(cx, SX, ix, jx);
    cell_of(cy, SY, iy, jy);
    cell_of(cz, SZ, iz, jz);
    wx = cos_weight(16'(shifted_coord(cx)));
    wy = cos_weight(16'(shifted_coord(cy)));
    wz = cos_weight(16'(shifted_coord(cz)));
    e00 = lerp_q16(longint'(lattice[flat_index(ix, iy, iz)]) << 16,
                   longint'(lattice[flat_index(jx, iy, iz)]) << 16, wx);
    e10 = lerp_q16(longint'(lattice[flat_index(ix, jy, iz)]) << 16,
                   longint'(lattice[flat_index(jx, jy, iz)]) << 16, wx);
    e01 = lerp_q16(longint'(lattice[flat_index(ix, iy, jz)]) << 16,
                   longint'(lattice[flat_index(jx, iy, jz)]) << 16, wx);
    e11 = lerp_q16(longint'(lattice[flat_index(ix, jy, jz)]) << 16,
                   longint'(lattice[flat_index(jx, jy, jz)]) << 16, wx);
    f0 = lerp_q16(e00, e10, wy);
    f1 = lerp_q16(e01, e11, wy);
    v = lerp_q16(f0, f1, wz);
    r = (v + 500) / 1000;
    if (r > 65535) r = 65535;
    return r[15:0];
  endfunction

  task automatic send_item(op_t op, logic [IDX_W-1:0] idx, lat_val_t val,
      logic signed [31:0] cx, logic signed [31:0] cy, logic signed [31:0] cz);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.operation = op;
    in_ch.entry_index = idx;
    in_ch.entry_value = val;
    in_ch.coord_x = cx;
    in_ch.coord_y = cy;
    in_ch.coord_z = cz;
    do @(posedge clk); while (!in_ch.ready);
    if (op == OP_WRITE) begin
      lattice[idx] = val;
      loaded[idx] = 1'b1;
    end else begin
      noise_expected.push_back(noise_at(cx, cy, cz));
    end
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_entry(int idx, lat_val_t val);
    send_item(OP_WRITE, idx[IDX_W-1:0], val, $urandom, $urandom, $urandom);
  endtask

  // Loads any unwritten corner with a random value before evaluating.
  task automatic eval_point(logic signed [31:0] cx, logic signed [31:0] cy,
      logic signed [31:0] cz);
    int xs [2], ys [2], zs [2], k;
    cell_of(cx, SX, xs[0], xs[1]);
    cell_of(cy, SY, ys[0], ys[1]);
    cell_of(cz, SZ, zs[0], zs[1]);
    for (int c = 0; c < 8; c++) begin
      k = flat_index(xs[c & 1], ys[(c >> 1) & 1], zs[(c >> 2) & 1]);
      if (!loaded[k]) write_entry(k, lat_val_t'($urandom_range(0, 999)));
    end
    send_item(OP_EVAL, IDX_W'($urandom), lat_val_t'($urandom), cx, cy, cz);
  endtask

  task automatic wait_drained();
    while (noise_expected.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    // Largest stored values at cell zero push the result past 16 bits.
    for (int c = 0; c < 8; c++)
      write_entry(flat_index(c & 1, (c >> 1) & 1, (c >> 2) & 1), 10'h3FF);
    // Far below the offset, every coordinate clamps to the origin.
    eval_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
    eval_point(-(32'sd15000 <<< 16) + 32'sh0000FFFF, 32'sh80000000, 32'sh80000000);
    write_entry(flat_index(1, 0, 0), 10'd0);
    write_entry(flat_index(0, 1, 1), 10'd999);
    eval_point(-(32'sd15000 <<< 16) + 32'sh00008000, 32'sh80000000,
               -(32'sd15000 <<< 16) + 32'sh00004000);
    // Integer part lands on the last cell, so the neighbor wraps to zero.
    eval_point(32'sh00078000, 32'sh0007FFFF, 32'sh00070001);
    eval_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    eval_point(32'sd0, 32'sd0, 32'sd0);
    write_entry(DEPTH - 1, 10'd0);
    wait_drained();
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 3)
        write_entry($urandom_range(0, DEPTH - 1),
                    ($urandom_range(0, 19) == 0) ? lat_val_t'($urandom) :
                    lat_val_t'($urandom_range(0, 999)));
      else if ($urandom_range(0, 3) == 0)
        eval_point(32'sh80000000 | $urandom, $urandom, 32'sh7FFF0000 | $urandom);
      else
        eval_point($urandom, $urandom, $urandom);
    end
  endtask

  // Output held off long enough to fill the pipeline and stall the input.
  task automatic test_backpressure();
    hold_cycles = 200;
    for (int n = 0; n < 40; n++) eval_point($urandom, $urandom, $urandom);
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (noise_expected.size() == 0) begin
        report_mismatch("unexpected result, noise_value", -1, out_ch.noise_value);
      end else begin
        if (out_ch.noise_value !== noise_expected[0])
          report_mismatch("noise_value", noise_expected[0], out_ch.noise_value);
        void'(noise_expected.pop_front());
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready = 1'b0;
        hold_cycles--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  initial begin
    #3000000;
    $display("[value_noise_3d_cosine_interp] ERROR");
    $finish;
  end

  initial begin
    error_count = 0;
    calm = 1'b0;
    hold_cycles = 0;
    for (int k = 0; k < DEPTH; k++) begin
      lattice[k] = '0;
      loaded[k] = 1'b0;
    end
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_WRITE;
    in_ch.entry_index = '0;
    in_ch.entry_value = '0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.coord_z = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(120);
    test_backpressure();
    test_random(120);
    calm = 1'b1;
    test_random(80);
    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("[value_noise_3d_cosine_interp] OK");
    else
      $display("[value_noise_3d_cosine_interp] ERROR");
    $finish;
  end

endmodule
